// ===== design/nnpo_pkg.sv =====
package nnpo_pkg;

  localparam int NODE_COUNT = 32;
  localparam int LIST_DEPTH = 32;
  localparam int DIST_BITS  = 16;

  localparam int NODE_FIELD_BITS = 5;
  localparam int DIST_FIELD_BITS = 16;
  localparam int REQ_BITS        = 2;

  localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
  localparam int IDX_BITS   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int DADDR_BITS = $clog2(NODE_COUNT * NODE_COUNT);
  localparam int DIST_DEPTH = NODE_COUNT * NODE_COUNT;

  localparam logic [REQ_BITS-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_RUN    = 2'd2;

  typedef struct packed {
    logic dist_we;
    logic append;
    logic run_start;
    logic scan_init;
    logic scan_step;
    logic swap_rd;
    logic swap_wr;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_done;
  } status_t;

endpackage

// ===== design/nearest_neighbor_path_order.sv =====
// Greedy nearest-neighbor tour builder. Load words (req_type 0 writes one entry of the
// node-to-node distance matrix, req_type 1 appends a vertex to the visit list) are taken
// one per cycle. A run word (req_type 2) starts at node 0 and emits the visit list in
// nearest-first order, ties to the earliest list position, with path_last on the final
// vertex; the list is empty afterwards and a run on an empty list emits nothing. Input
// stays stalled for the whole run: each emitted vertex takes a pipelined scan of the n
// vertices still in the list (through the list memory and the distance memory, one read
// port each), then a swap-remove, then waits until the output is taken.
// Distances never written read back undefined.
module nearest_neighbor_path_order (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [nnpo_pkg::REQ_BITS-1:0]        in_req_type,
  input  logic [nnpo_pkg::NODE_FIELD_BITS-1:0] in_from_node,
  input  logic [nnpo_pkg::NODE_FIELD_BITS-1:0] in_to_node,
  input  logic [nnpo_pkg::DIST_FIELD_BITS-1:0] in_distance_value,
  input  logic [nnpo_pkg::NODE_FIELD_BITS-1:0] in_visit_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nnpo_pkg::NODE_FIELD_BITS-1:0] out_path_vertex,
  output logic                                 out_path_last
);
  import nnpo_pkg::*;

  cmd_t    cmd;
  status_t status;

  nnpo_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cmd         (cmd)
  );

  nnpo_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_from_node      (in_from_node),
    .in_to_node        (in_to_node),
    .in_distance_value (in_distance_value),
    .in_visit_vertex   (in_visit_vertex),
    .out_path_vertex   (out_path_vertex),
    .out_path_last     (out_path_last)
  );

endmodule

// ===== design/nnpo_ctrl.sv =====
module nnpo_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [nnpo_pkg::REQ_BITS-1:0] in_req_type,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  nnpo_pkg::status_t             status,
  output nnpo_pkg::cmd_t                cmd
);
  import nnpo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP_RD,
    S_SWAP_WR,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_WRITE:  cmd.dist_we = 1'b1;
            REQ_APPEND: cmd.append  = 1'b1;
            REQ_RUN: begin
              if (!status.cnt_zero) begin
                cmd.run_start = 1'b1;
                cmd.scan_init = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_SWAP_RD;
        end
      end
      S_SWAP_RD: begin
        cmd.swap_rd = 1'b1;
        state_nxt   = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        cmd.swap_wr   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (status.cnt_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/nnpo_datapath.sv =====
module nnpo_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nnpo_pkg::cmd_t                       cmd,
  output nnpo_pkg::status_t                    status,
  input  logic [nnpo_pkg::NODE_FIELD_BITS-1:0] in_from_node,
  input  logic [nnpo_pkg::NODE_FIELD_BITS-1:0] in_to_node,
  input  logic [nnpo_pkg::DIST_FIELD_BITS-1:0] in_distance_value,
  input  logic [nnpo_pkg::NODE_FIELD_BITS-1:0] in_visit_vertex,
  output logic [nnpo_pkg::NODE_FIELD_BITS-1:0] out_path_vertex,
  output logic                                 out_path_last
);
  import nnpo_pkg::*;

  logic [DIST_BITS-1:0]       dist_mem [DIST_DEPTH];
  logic [NODE_FIELD_BITS-1:0] list_mem [LIST_DEPTH];

  logic [CNT_BITS-1:0]        cnt_r;
  logic [CNT_BITS-1:0]        cnt_m1;
  logic [CNT_BITS-1:0]        idx_r;
  logic [IDX_BITS-1:0]        idx1_r;
  logic [IDX_BITS-1:0]        idx2_r;
  logic                       s1_r;
  logic                       s2_r;
  logic                       issue;
  logic                       full;
  logic [IDX_BITS-1:0]        list_raddr;
  logic [NODE_FIELD_BITS-1:0] list_rd_r;
  logic [NODE_FIELD_BITS-1:0] cur_r;
  logic                       oor1;
  logic                       oor2_r;
  logic [NODE_FIELD_BITS-1:0] vtx2_r;
  logic [DADDR_BITS-1:0]      dist_raddr;
  logic [DADDR_BITS-1:0]      dist_waddr;
  logic                       waddr_ok;
  logic [DIST_BITS-1:0]       dist_rd_r;
  logic [DIST_BITS-1:0]       cand;
  logic                       best_valid_r;
  logic [DIST_BITS-1:0]       best_dist_r;
  logic [IDX_BITS-1:0]        best_idx_r;
  logic [NODE_FIELD_BITS-1:0] best_vtx_r;
  logic [NODE_FIELD_BITS-1:0] out_vertex_r;
  logic                       out_last_r;

  assign full   = (cnt_r == CNT_BITS'(LIST_DEPTH));
  assign cnt_m1 = cnt_r - CNT_BITS'(1);
  assign issue  = cmd.scan_step && (idx_r < cnt_r);

  assign status.cnt_zero  = (cnt_r == '0);
  assign status.scan_done = !(idx_r < cnt_r) && !s1_r && !s2_r;

  assign list_raddr = cmd.swap_rd ? cnt_m1[IDX_BITS-1:0] : idx_r[IDX_BITS-1:0];

  assign waddr_ok   = (int'(in_from_node) < NODE_COUNT) && (int'(in_to_node) < NODE_COUNT);
  assign dist_waddr = DADDR_BITS'(int'(in_from_node) * NODE_COUNT + int'(in_to_node));

  // row or column off the matrix reads as the largest distance
  assign oor1       = !((int'(cur_r) < NODE_COUNT) && (int'(list_rd_r) < NODE_COUNT));
  assign dist_raddr = oor1 ? '0 : DADDR_BITS'(int'(cur_r) * NODE_COUNT + int'(list_rd_r));

  assign cand = oor2_r ? '1 : dist_rd_r;

  assign out_path_vertex = out_vertex_r;
  assign out_path_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.dist_we && waddr_ok) begin
      dist_mem[dist_waddr] <= DIST_BITS'(in_distance_value);
    end
    dist_rd_r <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      list_mem[cnt_r[IDX_BITS-1:0]] <= in_visit_vertex;
    end else if (cmd.swap_wr) begin
      list_mem[best_idx_r] <= list_rd_r;
    end
    list_rd_r <= list_mem[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      idx_r        <= '0;
      s1_r         <= 1'b0;
      s2_r         <= 1'b0;
      best_valid_r <= 1'b0;
    end else begin
      if (cmd.append && !full) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
      end else if (cmd.swap_wr) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.scan_init) begin
        idx_r        <= '0;
        best_valid_r <= 1'b0;
      end else begin
        if (issue) begin
          idx_r <= idx_r + CNT_BITS'(1);
        end
        if (s2_r) begin
          best_valid_r <= 1'b1;
        end
      end
      s1_r <= issue;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= idx_r[IDX_BITS-1:0];
    idx2_r <= idx1_r;
    vtx2_r <= list_rd_r;
    oor2_r <= oor1;
    // strict compare keeps the earliest position on a tie
    if (s2_r && (!best_valid_r || (cand < best_dist_r))) begin
      best_dist_r <= cand;
      best_idx_r  <= idx2_r;
      best_vtx_r  <= vtx2_r;
    end
    if (cmd.run_start) begin
      cur_r <= '0;
    end else if (cmd.swap_wr) begin
      cur_r <= best_vtx_r;
    end
    if (cmd.swap_wr) begin
      out_vertex_r <= best_vtx_r;
      out_last_r   <= (cnt_r == CNT_BITS'(1));
    end
  end

endmodule

// ===== tb/sv/nearest_neighbor_path_order_tb.sv =====
module nearest_neighbor_path_order_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnpo_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_WORDS  = 320;
  localparam int QUIET_WORDS   = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 100;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int POOL_MAX      = 10;

  typedef logic [NODE_FIELD_BITS-1:0] node_t;

  typedef struct packed {
    node_t vertex;
    logic  last;
  } path_step_t;

  class path_scoreboard;
    logic [DIST_BITS-1:0] dist_mem [NODE_COUNT*NODE_COUNT];
    node_t visit_q [$];
    path_step_t expected_q [$];
    int errors = 0;

    function int pending();
      return expected_q.size();
    endfunction

    function int list_size();
      return visit_q.size();
    endfunction

    function logic [DIST_BITS-1:0] lookup(int row, int col);
      if (row >= NODE_COUNT || col >= NODE_COUNT) begin
        return '1;
      end
      return dist_mem[row*NODE_COUNT + col];
    endfunction

    // model update on every accepted word, greedy tour on run words
    function void note_word(logic [REQ_BITS-1:0] req, node_t from_n, node_t to_n,
                            logic [DIST_FIELD_BITS-1:0] dval, node_t vtx);
      int best;
      logic [DIST_BITS-1:0] best_d;
      logic [DIST_BITS-1:0] d;
      node_t cur;
      node_t chosen;
      path_step_t step;
      case (req)
        REQ_WRITE: begin
          if (int'(from_n) < NODE_COUNT && int'(to_n) < NODE_COUNT) begin
            dist_mem[int'(from_n)*NODE_COUNT + int'(to_n)] = dval[DIST_BITS-1:0];
          end
        end
        REQ_APPEND: begin
          if (visit_q.size() < LIST_DEPTH) begin
            visit_q = {visit_q, vtx};
          end
        end
        REQ_RUN: begin
          cur = '0;
          while (visit_q.size() > 0) begin
            best = 0;
            best_d = lookup(int'(cur), int'(visit_q[0]));
            for (int i = 1; i < visit_q.size(); i++) begin
              d = lookup(int'(cur), int'(visit_q[i]));
              if (d < best_d) begin
                best_d = d;
                best = i;
              end
            end
            chosen = visit_q[best];
            visit_q[best] = visit_q[visit_q.size()-1];
            visit_q.delete(visit_q.size()-1);
            cur = chosen;
            step.vertex = chosen;
            step.last = (visit_q.size() == 0);
            expected_q = {expected_q, step};
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_step(node_t vertex, logic last);
      path_step_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got vertex %0d last %0b",
                 $time, vertex, last);
        return;
      end
      want = expected_q.pop_front();
      if (vertex !== want.vertex) begin
        errors++;
        $display("%0t: path_vertex mismatch: expected %0d, got %0d",
                 $time, want.vertex, vertex);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: path_last mismatch: expected %0b, got %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [REQ_BITS-1:0] in_req_type;
  node_t in_from_node;
  node_t in_to_node;
  logic [DIST_FIELD_BITS-1:0] in_distance_value;
  node_t in_visit_vertex;
  logic out_valid;
  logic out_ready;
  node_t out_path_vertex;
  logic out_path_last;

  path_scoreboard sb = new();
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int words_done = 0;
  int unsigned cycle_count = 0;
  node_t pool [$];
  bit in_pool [NODE_COUNT];

  nearest_neighbor_path_order u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_from_node     (in_from_node),
    .in_to_node       (in_to_node),
    .in_distance_value(in_distance_value),
    .in_visit_vertex  (in_visit_vertex),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_path_vertex  (out_path_vertex),
    .out_path_last    (out_path_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check, then pick next ready
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        sb.check_step(out_path_vertex, out_path_last);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [DIST_FIELD_BITS-1:0] pick_distance();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return DIST_FIELD_BITS'($urandom_range(0, 3));
      default: return DIST_FIELD_BITS'($urandom);
    endcase
  endfunction

  function automatic node_t pool_node();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic send_word(input logic [REQ_BITS-1:0] req, input node_t from_n,
                           input node_t to_n, input logic [DIST_FIELD_BITS-1:0] dval,
                           input node_t vtx);
    bit counts;
    counts = (req == REQ_WRITE) ||
             (req == REQ_APPEND && sb.list_size() < LIST_DEPTH) ||
             (req == REQ_RUN && sb.list_size() > 0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_from_node <= from_n;
    in_to_node <= to_n;
    in_distance_value <= dval;
    in_visit_vertex <= vtx;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(req, from_n, to_n, dval, vtx);
    if (counts) begin
      words_done++;
    end
  endtask

  task automatic write_pool_entry();
    send_word(REQ_WRITE, pool_node(), pool_node(), pick_distance(), node_t'($urandom));
  endtask

  task automatic fill_and_run(input int count);
    repeat (count) begin
      send_word(REQ_APPEND, node_t'($urandom), node_t'($urandom), DIST_FIELD_BITS'($urandom),
                pool_node());
    end
    send_word(REQ_RUN, node_t'($urandom), node_t'($urandom), DIST_FIELD_BITS'($urandom),
              node_t'($urandom));
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // every pool node gets its row and column within the pool before it can be appended
  task automatic grow_pool();
    node_t v;
    do v = node_t'($urandom); while (in_pool[v]);
    foreach (pool[i]) begin
      send_word(REQ_WRITE, pool[i], v, pick_distance(), node_t'($urandom));
      send_word(REQ_WRITE, v, pool[i], pick_distance(), node_t'($urandom));
    end
    send_word(REQ_WRITE, v, v, pick_distance(), node_t'($urandom));
    pool = {pool, v};
    in_pool[v] = 1'b1;
  endtask

  initial begin
    node_t dir_nodes [4];
    logic [DIST_FIELD_BITS-1:0] dir_dist [16];
    bit hold_done;
    bit pause_done;
    dir_nodes = '{5'd0, 5'd10, 5'd21, 5'd31};
    // rows 0, 10, 21, 31; ties from node 0 and node 21
    dir_dist = '{16'd5, 16'd3, 16'd3, 16'hFFFF,
                 16'd1, 16'd0, 16'd2, 16'd4,
                 16'd7, 16'd7, 16'd0, 16'd100,
                 16'hFFFF, 16'd9, 16'd0, 16'd12};
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_WRITE;
    in_from_node <= '0;
    in_to_node <= '0;
    in_distance_value <= '0;
    in_visit_vertex <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        send_word(REQ_WRITE, dir_nodes[i], dir_nodes[j], dir_dist[i*4 + j], '1);
      end
    end
    for (int i = 3; i >= 0; i--) begin
      send_word(REQ_APPEND, '1, '0, '1, dir_nodes[i]);
    end
    send_word(REQ_RUN, '0, '1, '0, '1);
    send_word(REQ_RUN, '1, '0, '1, '0);
    send_word(REQ_UNUSED, '1, '1, '1, '1);
    foreach (dir_nodes[i]) begin
      pool = {pool, dir_nodes[i]};
      in_pool[dir_nodes[i]] = 1'b1;
    end
    words_done = 0;

    // full list, extra appends dropped
    fill_and_run(LIST_DEPTH + 2);
    while (words_done < RANDOM_WORDS) begin
      if (words_done >= RANDOM_WORDS - QUIET_WORDS) begin
        quiet = 1'b1;
      end
      if (!hold_done && words_done >= 100) begin
        hold_done = 1'b1;
        long_hold_req = 1'b1;
        fill_and_run(20);
        repeat (6) write_pool_entry();
      end else if (!pause_done && words_done >= 60) begin
        pause_done = 1'b1;
        drain_pause();
        fill_and_run($urandom_range(1, 4));
      end else begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3, 4, 5: begin
            repeat ($urandom_range(0, 2)) write_pool_entry();
            fill_and_run($urandom_range(1, 6));
          end
          6: begin
            if ($urandom_range(0, 3) == 0) begin
              fill_and_run(LIST_DEPTH + 1);
            end else begin
              fill_and_run($urandom_range(7, LIST_DEPTH - 1));
            end
          end
          7: begin
            if (pool.size() < POOL_MAX) begin
              grow_pool();
            end else begin
              write_pool_entry();
            end
          end
          8: begin
            send_word(REQ_WRITE, node_t'($urandom), node_t'($urandom), pick_distance(),
                      node_t'($urandom));
            send_word(REQ_UNUSED, node_t'($urandom), node_t'($urandom),
                      DIST_FIELD_BITS'($urandom), node_t'($urandom));
          end
          9: begin
            if (sb.list_size() == 0) begin
              send_word(REQ_RUN, node_t'($urandom), node_t'($urandom),
                        DIST_FIELD_BITS'($urandom), node_t'($urandom));
            end
            repeat ($urandom_range(1, 3)) begin
              send_word(REQ_APPEND, node_t'($urandom), node_t'($urandom),
                        DIST_FIELD_BITS'($urandom), pool_node());
            end
          end
          10: begin
            drain_pause();
            fill_and_run($urandom_range(1, 5));
          end
          default: begin
            repeat ($urandom_range(1, 3)) write_pool_entry();
            fill_and_run($urandom_range(2, 10));
          end
        endcase
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
